// ----- hdl/rtpl_pkg.sv -----
// Shared types, codes and helpers for the route table prefix lookup block.
// Used by the controller, the datapath and the top level; depends on nothing.
package rtpl_pkg;

   localparam int MAX_ROUTES_DEF = 16;
   localparam int LEN_W          = 6;

   localparam logic [1:0] FUNC_LOOKUP = 2'd0;
   localparam logic [1:0] FUNC_ADD    = 2'd1;
   localparam logic [1:0] FUNC_REMOVE = 2'd2;

   localparam logic [2:0] ST_VIA       = 3'd0;
   localparam logic [2:0] ST_DIRECT    = 3'd1;
   localparam logic [2:0] ST_NO_ROUTE  = 3'd2;
   localparam logic [2:0] ST_ADDED     = 3'd3;
   localparam logic [2:0] ST_FULL      = 3'd4;
   localparam logic [2:0] ST_REMOVED   = 3'd5;
   localparam logic [2:0] ST_PROTECTED = 3'd6;
   localparam logic [2:0] ST_NO_ENTRY  = 3'd7;

   localparam logic [1:0] REG_IFACE0_ADDR = 2'd0;
   localparam logic [1:0] REG_IFACE0_MASK = 2'd1;
   localparam logic [1:0] REG_IFACE1_ADDR = 2'd2;
   localparam logic [1:0] REG_IFACE1_MASK = 2'd3;

   typedef enum logic [1:0] {
      RD_K,
      RD_K_MINUS,
      RD_K_PLUS
   } rd_sel_type;

   typedef struct packed {
      logic [31:0]      net;
      logic [31:0]      mask;
      logic [31:0]      hop;
      logic [LEN_W-1:0] len;
   } route_type;

   typedef struct packed {
      logic       capture;
      logic       k_load_zero;
      logic       k_load_cnt;
      logic       k_load_idx;
      logic       k_inc;
      logic       k_dec;
      logic       rd_issue;
      rd_sel_type rd_sel;
      logic       wr_en;
      logic       wr_new;
      logic       cnt_inc;
      logic       cnt_dec;
      logic       rsp_load;
      logic [2:0] rsp_status;
   } cmd_type;

   typedef struct packed {
      logic [1:0] func;
      logic       iface_hit;
      logic       full;
      logic       protect;
      logic       missing;
      logic       k_at_cnt;
      logic       k_zero;
      logic       k_last;
      logic       match;
      logic       longer;
      logic       rsp_busy;
   } sts_type;

   // Number of one bits, summed over nibbles.
   function automatic logic [LEN_W-1:0] ones_of(input logic [31:0] v);
      logic [LEN_W-1:0] n;
      n = '0;
      for (int i = 0; i < 8; i++) begin
         n = n + LEN_W'(v[4*i]) + LEN_W'(v[4*i+1]) + LEN_W'(v[4*i+2]) + LEN_W'(v[4*i+3]);
      end
      return n;
   endfunction

endpackage

// ----- hdl/route_table_prefix_lookup.sv -----
// A direct hit or a rejected command goes straight to the result; a lookup compares the
// static routes in list order until one matches or the list ends; an add moves routes
// up from the tail until it finds its place; a removal moves each later route down.
// One beat at a time: the next is taken only once the result has loaded, later under
// stalls. Reset is synchronous, active high; it clears the sequencer, walk index,
// route count, result valid flag and interface registers.
module route_table_prefix_lookup #(
   parameter int MAX_ROUTES = rtpl_pkg::MAX_ROUTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [31:0] req_address,
   input  logic [31:0] req_route_mask,
   input  logic [31:0] req_next_hop,
   input  logic [4:0]  req_entry_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_hop_addr,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   rtpl_pkg::cmd_type cmd;
   rtpl_pkg::sts_type sts;

   logic [31:0] iface0_addr_ff, iface0_mask_ff, iface1_addr_ff, iface1_mask_ff;
   logic        csr_write;

   // The interface registers sit at word addresses; the low address bits are ignored.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         iface0_addr_ff <= 32'd0;
         iface0_mask_ff <= 32'hFFFF_FFFF;
         iface1_addr_ff <= 32'd0;
         iface1_mask_ff <= 32'hFFFF_FFFF;
      end else if (csr_write) begin
         unique case (paddr[3:2])
            rtpl_pkg::REG_IFACE0_ADDR: iface0_addr_ff <= pwdata;
            rtpl_pkg::REG_IFACE0_MASK: iface0_mask_ff <= pwdata;
            rtpl_pkg::REG_IFACE1_ADDR: iface1_addr_ff <= pwdata;
            rtpl_pkg::REG_IFACE1_MASK: iface1_mask_ff <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         rtpl_pkg::REG_IFACE0_ADDR: prdata = iface0_addr_ff;
         rtpl_pkg::REG_IFACE0_MASK: prdata = iface0_mask_ff;
         rtpl_pkg::REG_IFACE1_ADDR: prdata = iface1_addr_ff;
         rtpl_pkg::REG_IFACE1_MASK: prdata = iface1_mask_ff;
         default:                   prdata = 32'd0;
      endcase
   end

   // The sequencer owns the request handshake; the datapath owns the result register,
   // so a finished result can wait while the next beat is taken in.
   rtpl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   rtpl_dp #(
      .MAX_ROUTES (MAX_ROUTES)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_func        (req_func),
      .req_address     (req_address),
      .req_route_mask  (req_route_mask),
      .req_next_hop    (req_next_hop),
      .req_entry_index (req_entry_index),
      .iface0_addr     (iface0_addr_ff),
      .iface0_mask     (iface0_mask_ff),
      .iface1_addr     (iface1_addr_ff),
      .iface1_mask     (iface1_mask_ff),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_hop_addr    (rsp_hop_addr)
   );

endmodule

// ----- hdl/rtpl_ctrl.sv -----
// Sequencer for the route table: walks lookups, inserts and removals.
// Depends on rtpl_pkg; drives the datapath by command and reads its status.
module rtpl_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rtpl_pkg::sts_type sts,
   output rtpl_pkg::cmd_type cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_LK_RD,
      S_LK_CMP,
      S_ADD_RD,
      S_ADD_WR,
      S_RM_RD,
      S_RM_WR,
      S_DONE
   } state_type;

   state_type  state_ff, state_in;
   logic [2:0] result_ff, result_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in  = state_ff;
      result_in = result_ff;
      cmd       = '0;
      cmd.rd_sel     = rtpl_pkg::RD_K;
      cmd.rsp_status = result_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            state_in = S_DONE;
            case (sts.func)
               rtpl_pkg::FUNC_LOOKUP: begin
                  if (sts.iface_hit) begin
                     result_in = rtpl_pkg::ST_DIRECT;
                  end else begin
                     cmd.k_load_zero = 1'b1;
                     state_in        = S_LK_RD;
                  end
               end
               rtpl_pkg::FUNC_ADD: begin
                  if (sts.full) begin
                     result_in = rtpl_pkg::ST_FULL;
                  end else begin
                     cmd.k_load_cnt = 1'b1;
                     state_in       = S_ADD_RD;
                  end
               end
               rtpl_pkg::FUNC_REMOVE: begin
                  if (sts.protect) begin
                     result_in = rtpl_pkg::ST_PROTECTED;
                  end else if (sts.missing) begin
                     result_in = rtpl_pkg::ST_NO_ENTRY;
                  end else begin
                     cmd.k_load_idx = 1'b1;
                     state_in       = S_RM_RD;
                  end
               end
               default: result_in = rtpl_pkg::ST_NO_ENTRY;
            endcase
         end
         S_LK_RD: begin
            if (sts.k_at_cnt) begin
               result_in = rtpl_pkg::ST_NO_ROUTE;
               state_in  = S_DONE;
            end else begin
               cmd.rd_issue = 1'b1;
               state_in     = S_LK_CMP;
            end
         end
         S_LK_CMP: begin
            if (sts.match) begin
               result_in = rtpl_pkg::ST_VIA;
               state_in  = S_DONE;
            end else begin
               cmd.k_inc = 1'b1;
               state_in  = S_LK_RD;
            end
         end
         S_ADD_RD: begin
            if (sts.k_zero) begin
               cmd.wr_en   = 1'b1;
               cmd.wr_new  = 1'b1;
               cmd.cnt_inc = 1'b1;
               result_in   = rtpl_pkg::ST_ADDED;
               state_in    = S_DONE;
            end else begin
               cmd.rd_issue = 1'b1;
               cmd.rd_sel   = rtpl_pkg::RD_K_MINUS;
               state_in     = S_ADD_WR;
            end
         end
         S_ADD_WR: begin
            cmd.wr_en = 1'b1;
            if (sts.longer) begin
               cmd.wr_new  = 1'b1;
               cmd.cnt_inc = 1'b1;
               result_in   = rtpl_pkg::ST_ADDED;
               state_in    = S_DONE;
            end else begin
               cmd.k_dec = 1'b1;
               state_in  = S_ADD_RD;
            end
         end
         S_RM_RD: begin
            if (sts.k_last) begin
               cmd.cnt_dec = 1'b1;
               result_in   = rtpl_pkg::ST_REMOVED;
               state_in    = S_DONE;
            end else begin
               cmd.rd_issue = 1'b1;
               cmd.rd_sel   = rtpl_pkg::RD_K_PLUS;
               state_in     = S_RM_WR;
            end
         end
         S_RM_WR: begin
            cmd.wr_en = 1'b1;
            cmd.k_inc = 1'b1;
            state_in  = S_RM_RD;
         end
         S_DONE: begin
            if (!sts.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         result_ff <= rtpl_pkg::ST_NO_ENTRY;
      end else begin
         state_ff  <= state_in;
         result_ff <= result_in;
      end
   end

endmodule

// ----- hdl/rtpl_dp.sv -----
// Datapath of the route table: captured request, route memory, walk index,
// route count and the result register. Depends on rtpl_pkg.
module rtpl_dp #(
   parameter int MAX_ROUTES = rtpl_pkg::MAX_ROUTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  rtpl_pkg::cmd_type cmd,
   output rtpl_pkg::sts_type sts,
   input  logic [1:0]        req_func,
   input  logic [31:0]       req_address,
   input  logic [31:0]       req_route_mask,
   input  logic [31:0]       req_next_hop,
   input  logic [4:0]        req_entry_index,
   input  logic [31:0]       iface0_addr,
   input  logic [31:0]       iface0_mask,
   input  logic [31:0]       iface1_addr,
   input  logic [31:0]       iface1_mask,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [2:0]        rsp_status,
   output logic [31:0]       rsp_hop_addr
);

   localparam int IW = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;
   localparam int CW = $clog2(MAX_ROUTES + 1);
   localparam int XW = (CW > 5) ? CW : 5;

   logic [1:0]              func_ff;
   logic [31:0]             addr_ff, mask_ff, hop_ff;
   logic [4:0]              idx_ff;
   logic [rtpl_pkg::LEN_W-1:0] len_ff;
   logic [CW-1:0]           k_ff, k_in, cnt_ff, cnt_in;
   rtpl_pkg::route_type     mem [MAX_ROUTES];
   rtpl_pkg::route_type     rd_ff, wr_data;
   logic [CW-1:0]           rd_ptr;
   logic [XW-1:0]           slot;
   logic                    rsp_valid_ff;
   logic [2:0]              rsp_status_ff;
   logic [31:0]             rsp_hop_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff <= req_func;
         addr_ff <= req_address;
         mask_ff <= req_route_mask;
         hop_ff  <= req_next_hop;
         idx_ff  <= req_entry_index;
         len_ff  <= rtpl_pkg::ones_of(req_route_mask);
      end
   end

   // Static route position of a removal request.
   assign slot = XW'(idx_ff) - XW'(2);

   always_comb begin
      k_in = k_ff;
      if (cmd.k_load_zero) k_in = '0;
      else if (cmd.k_load_cnt) k_in = cnt_ff;
      else if (cmd.k_load_idx) k_in = CW'(slot);
      else if (cmd.k_inc) k_in = k_ff + CW'(1);
      else if (cmd.k_dec) k_in = k_ff - CW'(1);
      cnt_in = cnt_ff;
      if (cmd.cnt_inc) cnt_in = cnt_ff + CW'(1);
      else if (cmd.cnt_dec) cnt_in = cnt_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff   <= '0;
         cnt_ff <= '0;
      end else begin
         k_ff   <= k_in;
         cnt_ff <= cnt_in;
      end
   end

   always_comb begin
      case (cmd.rd_sel)
         rtpl_pkg::RD_K_MINUS: rd_ptr = k_ff - CW'(1);
         rtpl_pkg::RD_K_PLUS:  rd_ptr = k_ff + CW'(1);
         default:              rd_ptr = k_ff;
      endcase
      wr_data = rd_ff;
      if (cmd.wr_new) begin
         wr_data.net  = addr_ff;
         wr_data.mask = mask_ff;
         wr_data.hop  = hop_ff;
         wr_data.len  = len_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_issue) rd_ff <= mem[rd_ptr[IW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) mem[k_ff[IW-1:0]] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_status_ff <= cmd.rsp_status;
         rsp_hop_ff    <= (cmd.rsp_status == rtpl_pkg::ST_VIA) ? rd_ff.hop : 32'd0;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_hop_addr = rsp_hop_ff;

   always_comb begin
      sts.func      = func_ff;
      sts.iface_hit = ((addr_ff & iface1_mask) == (iface1_addr & iface1_mask)) ||
                      ((addr_ff & iface0_mask) == (iface0_addr & iface0_mask));
      sts.full      = (cnt_ff == CW'(MAX_ROUTES));
      sts.protect   = (idx_ff < 5'd2);
      sts.missing   = (slot >= XW'(cnt_ff));
      sts.k_at_cnt  = (k_ff == cnt_ff);
      sts.k_zero    = (k_ff == '0);
      sts.k_last    = (({1'b0, k_ff} + (CW+1)'(1)) >= {1'b0, cnt_ff});
      sts.match     = ((addr_ff & rd_ff.mask) == rd_ff.net);
      sts.longer    = (rd_ff.len > len_ff);
      sts.rsp_busy  = rsp_valid_ff && rsp_stall;
   end

endmodule

// ----- hdl/rtpl_checker.sv -----
// Port-level checks for the route table block, bound to the top level.
// Depends on rtpl_pkg for the status codes.
module rtpl_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_status,
   input logic [31:0] rsp_hop_addr
);

   // The block works on one beat at a time, so it is busy right after taking one.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while a previous one is still in flight");

   // Only a match on a static route carries a hop address.
   a_hop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != rtpl_pkg::ST_VIA) |-> (rsp_hop_addr == 32'd0))
      else $error("hop address set on a result that is not routed");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_status) && $stable(rsp_hop_addr))
      else $error("stalled result changed");

endmodule

bind route_table_prefix_lookup rtpl_checker u_rtpl_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_status   (rsp_status),
   .rsp_hop_addr (rsp_hop_addr)
);

// ----- test/route_table_prefix_lookup_checker.sv -----
// Checker for the route table prefix lookup block: snoops the register port and both
// channels, predicts each response, and compares it. Depends on rtpl_pkg.
`timescale 1ns / 100ps
module route_table_prefix_lookup_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [31:0] req_address,
   input  logic [31:0] req_route_mask,
   input  logic [31:0] req_next_hop,
   input  logic [4:0]  req_entry_index,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [2:0]  rsp_status,
   input  logic [31:0] rsp_hop_addr,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic        pready,
   output int          fail_count,
   output int          pending
);

   localparam int DEPTH = rtpl_pkg::MAX_ROUTES_DEF;

   typedef struct {
      logic [2:0]  status;
      logic [31:0] hop;
   } route_answer_type;

   logic [31:0] if0_addr, if0_mask, if1_addr, if1_mask;
   logic [31:0] net_tbl [DEPTH];
   logic [31:0] mask_tbl [DEPTH];
   logic [31:0] hop_tbl [DEPTH];
   int          route_cnt;
   route_answer_type answer_q [$];

   initial begin
      fail_count = 0;
      pending = 0;
   end

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch: %s got %h expected %h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   function automatic route_answer_type route_update(input logic [1:0] func,
         input logic [31:0] addr, input logic [31:0] mask, input logic [31:0] hop,
         input logic [4:0] idx);
      route_answer_type a;
      int pos;
      int s;
      a.status = rtpl_pkg::ST_NO_ENTRY;
      a.hop = '0;
      case (func)
         rtpl_pkg::FUNC_LOOKUP: begin
            a.status = rtpl_pkg::ST_NO_ROUTE;
            if ((addr & if1_mask) == (if1_addr & if1_mask) ||
                (addr & if0_mask) == (if0_addr & if0_mask)) begin
               a.status = rtpl_pkg::ST_DIRECT;
            end else begin
               for (int k = route_cnt - 1; k >= 0; k--) begin
                  // Walk backward so the first match in list order wins.
                  if ((addr & mask_tbl[k]) == net_tbl[k]) begin
                     a.status = rtpl_pkg::ST_VIA;
                     a.hop = hop_tbl[k];
                  end
               end
            end
         end
         rtpl_pkg::FUNC_ADD: begin
            if (route_cnt >= DEPTH) begin
               a.status = rtpl_pkg::ST_FULL;
            end else begin
               pos = 0;
               while (pos < route_cnt && $countones(mask_tbl[pos]) > $countones(mask))
                  pos++;
               for (int k = route_cnt; k > pos; k--) begin
                  net_tbl[k] = net_tbl[k-1];
                  mask_tbl[k] = mask_tbl[k-1];
                  hop_tbl[k] = hop_tbl[k-1];
               end
               net_tbl[pos] = addr;
               mask_tbl[pos] = mask;
               hop_tbl[pos] = hop;
               route_cnt++;
               a.status = rtpl_pkg::ST_ADDED;
            end
         end
         rtpl_pkg::FUNC_REMOVE: begin
            s = int'(idx) - 2;
            if (idx < 2) begin
               a.status = rtpl_pkg::ST_PROTECTED;
            end else if (s >= route_cnt) begin
               a.status = rtpl_pkg::ST_NO_ENTRY;
            end else begin
               for (int k = s; k + 1 < route_cnt; k++) begin
                  net_tbl[k] = net_tbl[k+1];
                  mask_tbl[k] = mask_tbl[k+1];
                  hop_tbl[k] = hop_tbl[k+1];
               end
               route_cnt--;
               a.status = rtpl_pkg::ST_REMOVED;
            end
         end
         default: a.status = rtpl_pkg::ST_NO_ENTRY;
      endcase
      return a;
   endfunction

   always @(posedge clock) begin
      route_answer_type want;
      if (reset) begin
         if0_addr = '0;
         if0_mask = '1;
         if1_addr = '0;
         if1_mask = '1;
         route_cnt = 0;
         answer_q.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
               rtpl_pkg::REG_IFACE0_ADDR: if0_addr = pwdata;
               rtpl_pkg::REG_IFACE0_MASK: if0_mask = pwdata;
               rtpl_pkg::REG_IFACE1_ADDR: if1_addr = pwdata;
               rtpl_pkg::REG_IFACE1_MASK: if1_mask = pwdata;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (answer_q.size() == 0) begin
               report("unexpected response status", 32'(rsp_status), 32'h0);
            end else begin
               want = answer_q.pop_front();
               if (rsp_status !== want.status)
                  report("status", 32'(rsp_status), 32'(want.status));
               if (rsp_hop_addr !== want.hop)
                  report("hop_addr", rsp_hop_addr, want.hop);
            end
         end
         if (req_valid && !req_stall)
            answer_q.push_back(route_update(req_func, req_address, req_route_mask,
                                            req_next_hop, req_entry_index));
      end
      pending = answer_q.size();
   end

endmodule

// ----- test/route_table_prefix_lookup_tb.sv -----
// Top of the route table prefix lookup testbench: clock, reset, register writes,
// request stimulus and response back-pressure. Depends on rtpl_pkg and the checker.
`timescale 1ns / 100ps
module route_table_prefix_lookup_tb;

   // Generous bound: about 550 beats, each at the worst walk length, plus stalls,
   // the long hold-off and the drains between phases.
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 400;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_func = '0;
   logic [31:0] req_address = '0;
   logic [31:0] req_route_mask = '0;
   logic [31:0] req_next_hop = '0;
   logic [4:0]  req_entry_index = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_hop_addr;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [3:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   int fail_count;
   int pending;
   int cycle_count = 0;

   // Stall controls: quiet mode stops idling on both sides; a hold request stalls responses.
   bit quiet_mode = 1'b0;
   bit hold_request = 1'b0;
   // The most recent networks added, up to 24; lookups mostly aim at one of them or an interface.
   logic [31:0] known_nets [$];
   logic [31:0] cur_if0_addr, cur_if1_addr;

   route_table_prefix_lookup DUT (.*);

   route_table_prefix_lookup_checker checker_inst (
      .clock, .reset, .req_valid, .req_stall, .req_func, .req_address,
      .req_route_mask, .req_next_hop, .req_entry_index, .rsp_valid, .rsp_stall,
      .rsp_status, .rsp_hop_addr, .psel, .penable, .pwrite, .paddr, .pwdata,
      .pready, .fail_count, .pending);

   initial begin
      forever #10 clock = ~clock;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("== FAIL ==");
         $finish;
      end
   end

   // Response stall. Normally stalls at random about a tenth of the time; in quiet mode it never
   // stalls, and a hold request keeps it stalled for a long counted stretch so that
   // the block backs up and stalls its request side.
   initial begin
      int held;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_stall = 1'b1;
            for (held = 1; held < HOLD_CYCLES; held++) @(negedge clock);
            hold_request = 1'b0;
            rsp_stall = 1'b0;
         end else if (quiet_mode) begin
            rsp_stall = 1'b0;
         end else begin
            rsp_stall = ($urandom_range(99) < 10);
         end
      end
   end

   // One register write: a setup phase, then the access phase that commits it.
   task automatic csr_write(input logic [1:0] index, input logic [31:0] value);
      @(negedge clock);
      psel = 1'b1;
      pwrite = 1'b1;
      penable = 1'b0;
      paddr = {index, 2'b00};
      pwdata = value;
      @(negedge clock);
      penable = 1'b1;
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
   endtask

   task automatic set_interfaces(input logic [31:0] a0, input logic [31:0] m0,
                                 input logic [31:0] a1, input logic [31:0] m1);
      csr_write(rtpl_pkg::REG_IFACE0_ADDR, a0);
      csr_write(rtpl_pkg::REG_IFACE0_MASK, m0);
      csr_write(rtpl_pkg::REG_IFACE1_ADDR, a1);
      csr_write(rtpl_pkg::REG_IFACE1_MASK, m1);
      cur_if0_addr = a0;
      cur_if1_addr = a1;
   endtask

   // Offer one beat and hold it until the block accepts it. Valid is only ever set
   // once per falling edge, so an idle gap or the next beat follows cleanly.
   task automatic send_beat(input logic [1:0] func, input logic [31:0] addr,
                            input logic [31:0] mask, input logic [31:0] hop,
                            input logic [4:0] idx);
      @(negedge clock);
      while (!quiet_mode && $urandom_range(99) < 10) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_func = func;
      req_address = addr;
      req_route_mask = mask;
      req_next_hop = hop;
      req_entry_index = idx;
      do @(posedge clock); while (req_stall);
   endtask

   // Drop valid and let every outstanding response come back before the block is
   // touched again.
   task automatic drain;
      @(negedge clock);
      req_valid = 1'b0;
      wait (pending == 0);
      repeat (50) @(posedge clock);
   endtask

   function automatic logic [31:0] prefix_mask(input int len);
      return (len == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - len));
   endfunction

   task automatic add_route(input logic [31:0] net, input logic [31:0] mask,
                            input logic [31:0] hop);
      known_nets.push_back(net);
      if (known_nets.size() > 24) void'(known_nets.pop_front());
      send_beat(rtpl_pkg::FUNC_ADD, net, mask, hop, 5'($urandom));
   endtask

   // A mostly well-formed command: lookups that hit stored routes or interfaces,
   // adds with contiguous prefixes, removes within or just past the list. About one
   // in twelve is raw noise across every bit, including the unused command code.
   task automatic random_beat(input int add_weight, input int remove_weight);
      int pick;
      int len;
      logic [31:0] mask;
      logic [31:0] addr;
      pick = $urandom_range(99);
      if ($urandom_range(11) == 0) begin
         send_beat(2'($urandom), $urandom, $urandom, $urandom, 5'($urandom));
      end else if (pick < add_weight) begin
         len = $urandom_range(32);
         mask = ($urandom_range(9) == 0) ? $urandom : prefix_mask(len);
         addr = $urandom;
         // Most nets are clean; a few keep host bits and can never match.
         if ($urandom_range(7) != 0) addr = addr & mask;
         add_route(addr, mask, ($urandom_range(9) == 0) ? {32{$urandom_range(1) == 1}}
                                                         : $urandom);
      end else if (pick < add_weight + remove_weight) begin
         send_beat(rtpl_pkg::FUNC_REMOVE, $urandom, $urandom, $urandom,
                   5'(($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(19)));
      end else begin
         addr = $urandom;
         case ($urandom_range(3))
            0: addr = addr;
            1: addr = cur_if0_addr ^ (addr & 32'h0000_00FF);
            2: addr = cur_if1_addr ^ (addr & 32'h0000_00FF);
            default: if (known_nets.size() != 0)
               addr = known_nets[$urandom_range(known_nets.size() - 1)] ^
                      (addr >> $urandom_range(31, 8));
         endcase
         send_beat(rtpl_pkg::FUNC_LOOKUP, addr, $urandom, $urandom, 5'($urandom));
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part under the reset interfaces (both are the host 0.0.0.0/32).
      set_interfaces(32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
      send_beat(rtpl_pkg::FUNC_LOOKUP, 32'h0, '0, '0, '0);         // direct on interface
      send_beat(rtpl_pkg::FUNC_LOOKUP, 32'hFFFF_FFFF, '1, '1, '1); // empty table
      send_beat(rtpl_pkg::FUNC_REMOVE, '0, '0, '0, 5'd0);          // protected entries
      send_beat(rtpl_pkg::FUNC_REMOVE, '0, '0, '0, 5'd1);
      send_beat(rtpl_pkg::FUNC_REMOVE, '0, '0, '0, 5'd2);          // missing, empty table
      send_beat(rtpl_pkg::FUNC_REMOVE, '0, '0, '0, 5'd31);
      send_beat(2'd3, '1, '1, '1, '1);                              // unknown command
      add_route(32'h0, 32'h0, 32'hFFFF_FFFF);                // default route, all-ones hop
      add_route(32'h0A00_0000, prefix_mask(8), 32'h0);       // hop of zero
      add_route(32'h0A01_0000, prefix_mask(16), 32'h1111_1111);
      add_route(32'h0A01_0200, prefix_mask(24), 32'h2222_2222);
      add_route(32'h0A01_0000, prefix_mask(16), 32'h3333_3333); // ties go first
      add_route(32'hC0A8_0101, prefix_mask(32), 32'h4444_4444);
      add_route(32'h0A02_00FF, prefix_mask(16), 32'h5555_5555); // host bits: dead
      send_beat(rtpl_pkg::FUNC_LOOKUP, 32'h0A01_0203, '0, '0, '0);
      send_beat(rtpl_pkg::FUNC_LOOKUP, 32'h0A01_0903, '0, '0, '0);
      send_beat(rtpl_pkg::FUNC_LOOKUP, 32'h0A02_00FF, '0, '0, '0);
      send_beat(rtpl_pkg::FUNC_LOOKUP, 32'hC0A8_0101, '0, '0, '0);
      send_beat(rtpl_pkg::FUNC_LOOKUP, 32'h7F00_0001, '0, '0, '0);
      send_beat(rtpl_pkg::FUNC_REMOVE, '0, '0, '0, 5'd2);
      send_beat(rtpl_pkg::FUNC_REMOVE, '0, '0, '0, 5'd7);
      send_beat(rtpl_pkg::FUNC_LOOKUP, 32'h0A01_0203, '0, '0, '0);
      drain();

      // Phase one: interfaces on /24 and /16, add-heavy so the table fills up.
      // The first stretch runs without any idling on either side.
      set_interfaces(32'hC0A8_0A01, prefix_mask(24), 32'hAC10_0001, prefix_mask(16));
      quiet_mode = 1'b1;
      repeat (60) random_beat(45, 10);
      quiet_mode = 1'b0;
      // Long receiver hold-off while requests keep coming.
      hold_request = 1'b1;
      repeat (60) random_beat(45, 10);
      // The sender pauses until everything has come back, then resumes.
      @(negedge clock);
      req_valid = 1'b0;
      wait (pending == 0);
      repeat (40) random_beat(30, 30);
      drain();

      // Phase two: interface masks of zero; every lookup is direct.
      set_interfaces(32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0);
      repeat (60) random_beat(30, 30);
      drain();

      // Phase three: all-ones addresses with /32 masks, remove-heavy to empty it.
      set_interfaces(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      repeat (110) random_beat(15, 50);
      drain();

      // Phase four: random interfaces and ragged masks, balanced mix.
      set_interfaces($urandom, prefix_mask($urandom_range(1, 31)), $urandom, $urandom);
      repeat (110) random_beat(35, 25);
      drain();

      // Phase five: back to the reset values, add-heavy again.
      set_interfaces(32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
      repeat (90) random_beat(40, 20);
      drain();

      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
